@@ rtl/priority_request_state_selector_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the priority request state selector
// Concurrent checks, clocked on the rising edge and held off during reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_REQUEST_STATE_SELECTOR_UNIT_ASSERT_SVH
`define PRIORITY_REQUEST_STATE_SELECTOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PRSU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prsu assertion failed");
// next-cycle implication
`define PRSU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prsu assertion failed");
`else
`define PRSU_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define PRSU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ rtl/prsu_pkg.sv @@
// ----------------------------------------------------------------------------
// prsu_pkg
// Shared constants, codes and types of the priority request state selector.
// ----------------------------------------------------------------------------
package prsu_pkg;

   localparam int NUM_STATES    = 8;
   localparam int PRIORITY_BITS = 16;
   localparam int STATE_W       = 3;
   localparam int RAW_PRIO_W    = 16;

   typedef enum logic [1:0] {
      ACT_REQUEST = 2'd0,
      ACT_RESOLVE = 2'd1,
      ACT_CLEAR   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CSR_REGISTERED_MASK   = 2'd0,
      CSR_RULE_PRESENT_MASK = 2'd1,
      CSR_ALLOWED_MATRIX    = 2'd2,
      CSR_INITIAL_STATE     = 2'd3
   } csr_index_type;

   // write / clear command broadcast to every cell
   typedef struct packed {
      logic                            wr;
      logic                            clear;
      logic [STATE_W-1:0]              target;
      logic signed [PRIORITY_BITS-1:0] prio;
   } cell_ctrl_type;

   // running best candidate handed from cell to cell
   typedef struct packed {
      logic                            vld;
      logic                            found;
      logic signed [PRIORITY_BITS-1:0] prio;
      logic [STATE_W-1:0]              idx;
   } carry_type;

   localparam logic signed [32:0] PRIO_HI = (33'sd1 <<< (PRIORITY_BITS - 1)) - 33'sd1;
   localparam logic signed [32:0] PRIO_LO = -PRIO_HI - 33'sd1;

   // sign-extend the raw priority and saturate it to PRIORITY_BITS
   function automatic logic signed [PRIORITY_BITS-1:0] fit_priority(
      input logic [RAW_PRIO_W-1:0] raw);
      logic signed [32:0]              wide;
      logic signed [PRIORITY_BITS-1:0] res;
      wide = {{(33 - RAW_PRIO_W){raw[RAW_PRIO_W-1]}}, raw};
      if (wide > PRIO_HI) begin
         res = PRIO_HI[PRIORITY_BITS-1:0];
      end else if (wide < PRIO_LO) begin
         res = PRIO_LO[PRIORITY_BITS-1:0];
      end else begin
         res = wide[PRIORITY_BITS-1:0];
      end
      return res;
   endfunction

endpackage

@@ rtl/prsu_cell.sv @@
// ----------------------------------------------------------------------------
// prsu_cell
// One pending-request slot: keeps its valid bit and best priority, and merges
// itself into the best candidate passing down the chain.
// ----------------------------------------------------------------------------
module prsu_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [prsu_pkg::STATE_W-1:0] cell_index,
   input  prsu_pkg::cell_ctrl_type  ctrl,
   input  prsu_pkg::carry_type      carry_in,
   output prsu_pkg::carry_type      carry_out,
   output logic                     pend_valid
);

   logic                                      valid_ff, valid_in;
   logic signed [prsu_pkg::PRIORITY_BITS-1:0] prio_ff, prio_in;
   prsu_pkg::carry_type                       carry_ff, carry_in_nxt;
   logic                                      hit;
   logic                                      take;

   always_comb begin
      hit  = ctrl.wr && (ctrl.target == cell_index);
      take = valid_ff && (!carry_in.found || (prio_ff > carry_in.prio));

      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (hit) begin
         valid_in = 1'b1;
      end

      prio_in = prio_ff;
      if (hit && (!valid_ff || (ctrl.prio > prio_ff))) begin
         prio_in = ctrl.prio;
      end

      carry_in_nxt = carry_in;
      if (take) begin
         carry_in_nxt.found = 1'b1;
         carry_in_nxt.prio  = prio_ff;
         carry_in_nxt.idx   = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff        <= prio_in;
      carry_ff.found <= carry_in_nxt.found;
      carry_ff.prio  <= carry_in_nxt.prio;
      carry_ff.idx   <= carry_in_nxt.idx;
      if (reset) begin
         valid_ff     <= 1'b0;
         carry_ff.vld <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         carry_ff.vld <= carry_in_nxt.vld;
      end
   end

   assign carry_out  = carry_ff;
   assign pend_valid = valid_ff;

endmodule

@@ rtl/priority_request_state_selector_unit.sv @@
// ----------------------------------------------------------------------------
// priority_request_state_selector_unit
// Priority-arbitrated state machine over up to eight states. Request, clear
// and unused action codes give their response in the cycle after acceptance.
// A resolve passes a best-candidate token down a row of NUM_STATES cells,
// one cell per cycle, each cell registering it; the response is registered
// once the token leaves the last cell. One request is in flight at a time,
// and a response waiting in the output register holds off the next request
// until it is taken.
// ----------------------------------------------------------------------------
`include "priority_request_state_selector_unit_assert.svh"

module priority_request_state_selector_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [2:0] target_state, [18:3] request_priority
   input  logic [1:0]  req_tuser,   // [1:0] action
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] current_state, [5:3] previous_state,
                                    // [6] state_changed, [7] update_issued,
                                    // [8] request_accepted
   // configuration
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } fsm_state_type;

   localparam int N  = prsu_pkg::NUM_STATES;
   localparam int SW = prsu_pkg::STATE_W;

   fsm_state_type           state_ff, state_in;
   logic [7:0]              registered_ff, registered_in;
   logic [7:0]              rule_ff, rule_in;
   logic [63:0]             allowed_ff, allowed_in;
   logic [SW-1:0]           present_ff, present_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [15:0]             rsp_data_ff, rsp_data_in;

   prsu_pkg::action_type    action;
   logic [SW-1:0]           target;
   logic                    accept;
   logic                    allowed;
   logic                    scan_done;
   logic                    changed;
   logic [SW-1:0]           chosen;
   prsu_pkg::cell_ctrl_type ctrl;
   prsu_pkg::carry_type     carry [N+1];
   logic [N-1:0]            pend_valid;

   assign action     = prsu_pkg::action_type'(req_tuser[1:0]);
   assign target     = req_tdata[2:0];
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign allowed = ({1'b0, target} < 4'(N)) && registered_ff[target] &&
                    (!rule_ff[present_ff] || allowed_ff[{present_ff, target}]);

   assign scan_done = (state_ff == ST_SCAN) && carry[N].vld;
   assign chosen    = carry[N].found ? carry[N].idx : present_ff;
   assign changed   = carry[N].found && (carry[N].idx != present_ff);

   always_comb begin
      ctrl.wr     = accept && (action == prsu_pkg::ACT_REQUEST) && allowed;
      ctrl.clear  = (accept && (action == prsu_pkg::ACT_CLEAR)) || scan_done;
      ctrl.target = target;
      ctrl.prio   = prsu_pkg::fit_priority(req_tdata[18:3]);

      carry[0].vld   = accept && (action == prsu_pkg::ACT_RESOLVE);
      carry[0].found = 1'b0;
      carry[0].prio  = '0;
      carry[0].idx   = '0;
   end

   for (genvar g = 0; g < N; g++) begin : g_cell
      prsu_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (SW'(g)),
         .ctrl       (ctrl),
         .carry_in   (carry[g]),
         .carry_out  (carry[g+1]),
         .pend_valid (pend_valid[g])
      );
   end

   always_comb begin
      registered_in = registered_ff;
      rule_in       = rule_ff;
      allowed_in    = allowed_ff;
      present_in    = present_ff;
      if (scan_done) begin
         present_in = chosen;
      end
      if (csr_wr_en) begin
         unique case (prsu_pkg::csr_index_type'(csr_index))
            prsu_pkg::CSR_REGISTERED_MASK:   registered_in = csr_wdata[7:0];
            prsu_pkg::CSR_RULE_PRESENT_MASK: rule_in       = csr_wdata[7:0];
            prsu_pkg::CSR_ALLOWED_MATRIX:    allowed_in    = csr_wdata;
            prsu_pkg::CSR_INITIAL_STATE:     present_in    = csr_wdata[SW-1:0];
            default:                         present_in    = present_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (action == prsu_pkg::ACT_RESOLVE) begin
                  state_in = ST_SCAN;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {7'd0, ctrl.wr, 1'b0, 1'b0, present_ff, present_ff};
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'd0, 1'b0, 1'b1, changed, present_ff, chosen};
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         registered_ff <= 8'hFF;
         rule_ff       <= 8'h00;
         allowed_ff    <= 64'd0;
         present_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         registered_ff <= registered_in;
         rule_ff       <= rule_in;
         allowed_ff    <= allowed_in;
         present_ff    <= present_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `PRSU_ASSERT_NOW(a_token_only_in_scan, clock, reset, carry[N].vld, state_ff == ST_SCAN)
   `PRSU_ASSERT_NOW(a_rsp_free_at_done, clock, reset, scan_done, !rsp_valid_ff)
   `PRSU_ASSERT_NEXT(a_pending_cleared, clock, reset, scan_done, pend_valid == '0)
   `PRSU_ASSERT_NEXT(a_state_hold_idle, clock, reset, (state_ff == ST_IDLE) && !csr_wr_en, $stable(present_ff))

endmodule

@@ test/tb_priority_request_state_selector_unit.sv @@
// ----------------------------------------------------------------------------
// tb_priority_request_state_selector_unit
// Self-checking bench for the priority request state selector. A short
// directed table covers reset behavior, priority extremes, ties, clears and
// the unused action code. Random requests then run under several register
// settings. Responses are checked against typed rows or an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_priority_request_state_selector_unit;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int NUM_PHASES = 9;

   typedef struct packed {
      logic [prsu_pkg::STATE_W-1:0] current_state;
      logic [prsu_pkg::STATE_W-1:0] previous_state;
      logic                         state_changed;
      logic                         update_issued;
      logic                         request_accepted;
   } selector_result_type;

   typedef struct packed {
      logic [1:0]                      act;
      logic [prsu_pkg::STATE_W-1:0]    tgt;
      logic [prsu_pkg::RAW_PRIO_W-1:0] prio;
      logic                            typed;
      selector_result_type             rsp;
   } directed_row_type;

   typedef struct packed {
      logic [7:0]                   exists_mask;
      logic [7:0]                   rule_mask;
      logic [63:0]                  allowed;
      logic [prsu_pkg::STATE_W-1:0] start_state;
   } selector_csr_type;

   // rows marked typed carry an expectation read straight off the spec
   localparam directed_row_type DIRECTED [19] = '{
      '{prsu_pkg::ACT_REQUEST, 3'd0, 16'h0000, 1'b1, '{3'd0, 3'd0, 1'b0, 1'b0, 1'b1}},
      '{prsu_pkg::ACT_RESOLVE, 3'd0, 16'h0000, 1'b1, '{3'd0, 3'd0, 1'b0, 1'b1, 1'b0}},
      '{prsu_pkg::ACT_RESOLVE, 3'd4, 16'h1234, 1'b1, '{3'd0, 3'd0, 1'b0, 1'b1, 1'b0}},
      '{prsu_pkg::ACT_REQUEST, 3'd7, 16'h7FFF, 1'b1, '{3'd0, 3'd0, 1'b0, 1'b0, 1'b1}},
      '{prsu_pkg::ACT_REQUEST, 3'd3, 16'h8000, 1'b1, '{3'd0, 3'd0, 1'b0, 1'b0, 1'b1}},
      '{prsu_pkg::ACT_REQUEST, 3'd7, 16'hFFFB, 1'b1, '{3'd0, 3'd0, 1'b0, 1'b0, 1'b1}},
      '{prsu_pkg::ACT_RESOLVE, 3'd0, 16'h0000, 1'b1, '{3'd7, 3'd0, 1'b1, 1'b1, 1'b0}},
      '{prsu_pkg::ACT_REQUEST, 3'd2, 16'd100,  1'b0, '0},
      '{prsu_pkg::ACT_REQUEST, 3'd5, 16'd100,  1'b0, '0},
      '{prsu_pkg::ACT_RESOLVE, 3'd0, 16'h0000, 1'b0, '0},
      '{prsu_pkg::ACT_REQUEST, 3'd4, 16'h8000, 1'b0, '0},
      '{prsu_pkg::ACT_CLEAR,   3'd0, 16'h0000, 1'b0, '0},
      '{prsu_pkg::ACT_RESOLVE, 3'd0, 16'h0000, 1'b0, '0},
      '{ACT_UNUSED,            3'd5, 16'h5555, 1'b1, '{3'd2, 3'd2, 1'b0, 1'b0, 1'b0}},
      '{prsu_pkg::ACT_REQUEST, 3'd6, 16'h2AAA, 1'b0, '0},
      '{prsu_pkg::ACT_REQUEST, 3'd1, 16'hD555, 1'b0, '0},
      '{prsu_pkg::ACT_RESOLVE, 3'd0, 16'h0000, 1'b0, '0},
      '{prsu_pkg::ACT_REQUEST, 3'd6, 16'h0001, 1'b0, '0},
      '{prsu_pkg::ACT_REQUEST, 3'd3, 16'hFFFF, 1'b0, '0}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;    // [2:0] target_state, [18:3] request_priority
   logic [1:0]  req_tuser;    // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;    // [2:0] current_state, [5:3] previous_state,
                              // [6] state_changed, [7] update_issued,
                              // [8] request_accepted
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;

   // predictor state
   logic [7:0]                                sel_exists;
   logic [7:0]                                sel_rule;
   logic [63:0]                               sel_allowed;
   logic [prsu_pkg::STATE_W-1:0]              sel_present;
   logic                                      sel_pend_valid [8];
   logic signed [prsu_pkg::PRIORITY_BITS-1:0] sel_pend_prio [8];

   selector_result_type expected_selections [$];

   int  mismatch_count  = 0;
   int  responses_seen  = 0;
   int  accepted_seen   = 0;
   int  switches_seen   = 0;
   int  items_sent      = 0;
   int  rsp_hold        = 0;
   bit  rsp_stalls_on   = 1'b1;
   bit  send_gaps_on    = 1'b1;

   priority_request_state_selector_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("%0t: timeout, %0d responses still outstanding", $time,
               expected_selections.size());
      $display("*** FAILED ***");
      $finish;
   end

   // sign-extend, then saturate to the configured priority width
   function automatic logic signed [prsu_pkg::PRIORITY_BITS-1:0] clamp_priority(
      input logic [prsu_pkg::RAW_PRIO_W-1:0] raw);
      longint wide;
      longint top;
      longint bottom;
      wide   = longint'($signed(raw));
      top    = (longint'(1) <<< (prsu_pkg::PRIORITY_BITS - 1)) - 1;
      bottom = -top - 1;
      if (wide > top) begin
         wide = top;
      end else if (wide < bottom) begin
         wide = bottom;
      end
      return wide[prsu_pkg::PRIORITY_BITS-1:0];
   endfunction

   function automatic selector_result_type predict_selection(
      input logic [1:0] act, input logic [prsu_pkg::STATE_W-1:0] tgt,
      input logic [prsu_pkg::RAW_PRIO_W-1:0] raw);
      selector_result_type                       res;
      logic                                      ok;
      logic                                      found;
      logic signed [prsu_pkg::PRIORITY_BITS-1:0] best_prio;
      logic signed [prsu_pkg::PRIORITY_BITS-1:0] p;
      logic [prsu_pkg::STATE_W-1:0]              best_idx;
      res                = '0;
      res.previous_state = sel_present;
      best_prio          = '0;
      best_idx           = sel_present;
      found              = 1'b0;
      if (act == prsu_pkg::ACT_REQUEST) begin
         ok = (int'(tgt) < prsu_pkg::NUM_STATES) && sel_exists[tgt];
         if (ok && sel_rule[sel_present]) begin
            ok = sel_allowed[int'(sel_present) * 8 + int'(tgt)];
         end
         if (ok) begin
            p = clamp_priority(raw);
            res.request_accepted = 1'b1;
            if (!sel_pend_valid[tgt] || p > sel_pend_prio[tgt]) begin
               sel_pend_prio[tgt] = p;
            end
            sel_pend_valid[tgt] = 1'b1;
         end
      end else if (act == prsu_pkg::ACT_RESOLVE) begin
         for (int i = 0; i < 8; i++) begin
            if (sel_pend_valid[i] && (!found || sel_pend_prio[i] > best_prio)) begin
               found     = 1'b1;
               best_prio = sel_pend_prio[i];
               best_idx  = i[prsu_pkg::STATE_W-1:0];
            end
            sel_pend_valid[i] = 1'b0;
         end
         if (found && best_idx != sel_present) begin
            sel_present       = best_idx;
            res.state_changed = 1'b1;
         end
         res.update_issued = 1'b1;
      end else if (act == prsu_pkg::ACT_CLEAR) begin
         for (int i = 0; i < 8; i++) begin
            sel_pend_valid[i] = 1'b0;
         end
      end
      res.current_state = sel_present;
      return res;
   endfunction

   // called just after a falling edge; returns just after a falling edge
   task automatic send_item(input logic [1:0] act,
                            input logic [prsu_pkg::STATE_W-1:0] tgt,
                            input logic [prsu_pkg::RAW_PRIO_W-1:0] prio,
                            input logic typed,
                            input selector_result_type typed_rsp);
      selector_result_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {5'd0, prio, tgt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_selection(act, tgt, prio);
      expected_selections.push_back(typed ? typed_rsp : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic sender_gap();
      if (send_gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
   endtask

   // block must be idle: valid low and nothing outstanding
   task automatic write_settings(input selector_csr_type s);
      csr_wr_en <= 1'b1;
      csr_index <= prsu_pkg::CSR_REGISTERED_MASK;
      csr_wdata <= {56'd0, s.exists_mask};
      @(negedge clock);
      csr_index <= prsu_pkg::CSR_RULE_PRESENT_MASK;
      csr_wdata <= {56'd0, s.rule_mask};
      @(negedge clock);
      csr_index <= prsu_pkg::CSR_ALLOWED_MATRIX;
      csr_wdata <= s.allowed;
      @(negedge clock);
      csr_index <= prsu_pkg::CSR_INITIAL_STATE;
      csr_wdata <= {61'd0, s.start_state};
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sel_exists  = s.exists_mask;
      sel_rule    = s.rule_mask;
      sel_allowed = s.allowed;
      sel_present = s.start_state;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
         rsp_hold   <= $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_responses
      selector_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen++;
         if (expected_selections.size() == 0) begin
            $display("%0t: response with none expected, expected nothing, got %h",
                     $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_selections.pop_front();
            check_field("current_state", want.current_state, rsp_tdata[2:0]);
            check_field("previous_state", want.previous_state, rsp_tdata[5:3]);
            check_field("state_changed", want.state_changed, rsp_tdata[6]);
            check_field("update_issued", want.update_issued, rsp_tdata[7]);
            check_field("request_accepted", want.request_accepted, rsp_tdata[8]);
            accepted_seen += want.request_accepted;
            switches_seen += want.state_changed;
         end
      end
   end

   initial begin : stimulus
      selector_csr_type                phase_cfg [NUM_PHASES];
      int                              phase_items [NUM_PHASES];
      int                              done;
      int                              r;
      logic [1:0]                      act;
      logic [prsu_pkg::STATE_W-1:0]    tgt;
      logic [prsu_pkg::RAW_PRIO_W-1:0] prio;

      phase_items = '{175, 60, 175, 60, 175, 175, 175, 175, 175};
      phase_cfg[0] = '{8'hFF, 8'h00, 64'd0, 3'd0};
      phase_cfg[1] = '{8'h00, 8'h00, 64'd0, 3'd7};
      phase_cfg[2] = '{8'hFF, 8'hFF, {64{1'b1}}, 3'd3};
      phase_cfg[3] = '{8'hFF, 8'hFF, 64'd0, 3'd5};
      for (int p = 4; p < NUM_PHASES; p++) begin
         phase_cfg[p].exists_mask = 8'($urandom | $urandom);
         phase_cfg[p].rule_mask   = 8'($urandom);
         phase_cfg[p].allowed     = {$urandom, $urandom} | {$urandom, $urandom};
         phase_cfg[p].start_state = 3'($urandom);
      end

      sel_exists  = 8'hFF;
      sel_rule    = 8'h00;
      sel_allowed = 64'd0;
      sel_present = '0;
      for (int i = 0; i < 8; i++) begin
         sel_pend_valid[i] = 1'b0;
         sel_pend_prio[i]  = '0;
      end

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_wr_en  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[i]) begin
         sender_gap();
         send_item(DIRECTED[i].act, DIRECTED[i].tgt, DIRECTED[i].prio,
                   DIRECTED[i].typed, DIRECTED[i].rsp);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         // drain before touching registers; pending requests stay in the block
         req_tvalid <= 1'b0;
         while (expected_selections.size() != 0) @(negedge clock);
         repeat (2) @(negedge clock);
         write_settings(phase_cfg[p]);
         send_gaps_on  = (p != 4) && (p != NUM_PHASES - 1);
         rsp_stalls_on = (p != 5) && (p != NUM_PHASES - 1);
         done = 0;
         while (done < phase_items[p]) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               act = prsu_pkg::ACT_REQUEST;
            end else if (r < 85) begin
               act = prsu_pkg::ACT_RESOLVE;
            end else if (r < 93) begin
               act = prsu_pkg::ACT_CLEAR;
            end else begin
               act = ACT_UNUSED;
            end
            tgt = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 3))
               0: begin
                  case ($urandom_range(0, 4))
                     0:       prio = 16'h8000;
                     1:       prio = 16'h7FFF;
                     2:       prio = 16'h0000;
                     3:       prio = 16'h0001;
                     default: prio = 16'hFFFF;
                  endcase
               end
               1:       prio = 16'($urandom_range(0, 15));
               default: prio = 16'($urandom);
            endcase
            sender_gap();
            send_item(act, tgt, prio, 1'b0, '0);
            done++;
         end
      end

      req_tvalid <= 1'b0;
      while (expected_selections.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Sent %0d requests (directed table, then %0d register settings);",
               items_sent, NUM_PHASES);
      $display("%0d responses checked, %0d accepted target requests, %0d state switches.",
               responses_seen, accepted_seen, switches_seen);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches.", mismatch_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/prsu_pkg.sv
rtl/prsu_cell.sv
rtl/priority_request_state_selector_unit.sv
test/tb_priority_request_state_selector_unit.sv
